// ===== hdl/fea_pkg.sv =====
package fea_pkg;

  localparam int MAX_EXTENTS_DEF = 64;

  localparam logic CMD_RELEASE  = 1'b0;
  localparam logic CMD_ALLOCATE = 1'b1;

  typedef struct packed {
    logic        command;
    logic [31:0] extent_start;
    logic [31:0] extent_length;
  } cmd_t;

  typedef struct packed {
    logic        found;
    logic [31:0] alloc_start;
    logic        overflow;
  } result_t;

  // one free extent as held in memory
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } extent_t;

endpackage

// ===== hdl/fea_ram.sv =====
module fea_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/free_extent_allocator.sv =====
// Free extent allocator: first-fit over a sorted list of free extents.
//
// Channels: an item (command, extent_start, extent_length as cmd_t) is taken
// on a rising edge with start high and busy low. busy is high from the next
// cycle for as long as the item is processed. The result (found, alloc_start,
// overflow as result_t) is on result for exactly one cycle with done high, in
// the cycle in which busy falls; the receiver cannot stall it. A new item may be
// taken in that same cycle.
//
// The extents live in one registered-read RAM. An item scans the list one
// entry a cycle up to its stop position p, then passes a decision state (an
// allocate with no fit skips it and the rest), moves each entry on an insertion
// or removal with a read and a write state, passes a write state where needed
// and a closing state. No read whose data is used shares a cycle with a write,
// so no forwarding is needed. Worst case is an insertion at the head of 63
// entries. The block takes no new item while it is busy.
//
// Reset clears the entry count, the sequencer and done only; the RAM is not
// cleared, since entries at or beyond the count are never used.
module free_extent_allocator #(
  parameter int MAX_EXTENTS = fea_pkg::MAX_EXTENTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fea_pkg::cmd_t    item,
  output logic             busy,
  output logic             done,
  output fea_pkg::result_t result
);

  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_SHRD = 3'd3;
  localparam logic [2:0] S_SHWR = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]       state;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;       // entry being examined or written
  logic [CW-1:0]    pos;
  fea_pkg::cmd_t    cur;
  fea_pkg::extent_t prev;      // entry at pos-1
  logic             have_prev;
  fea_pkg::extent_t nxt;       // entry at pos
  logic             nxt_valid;
  logic             grow;      // shift direction: 1 insert, 0 remove
  fea_pkg::extent_t hold;      // entry to be written last

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  fea_pkg::extent_t wdata, rdata;

  fea_ram #(.WIDTH($bits(fea_pkg::extent_t)), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // rdata holds the entry at idx while scanning
  logic        in_list;
  logic        stop_rel, fit;
  logic [31:0] sum_end, prev_end;
  assign in_list  = idx < count;
  assign stop_rel = !in_list || !(rdata.start < cur.extent_start);
  assign fit      = in_list && rdata.length >= cur.extent_length;
  assign sum_end  = cur.extent_start + cur.extent_length;
  assign prev_end = prev.start + prev.length;

  assign busy = state != S_IDLE;

  always_comb begin
    we    = 1'b0;
    waddr = idx[AW-1:0];
    wdata = hold;
    raddr = idx[AW-1:0];
    unique case (state)
      S_IDLE: begin
        raddr = '0;
      end
      S_SCAN: begin
        raddr = AW'(idx + CW'(1));
      end
      S_SHRD: begin
        raddr = grow ? AW'(idx - CW'(1)) : AW'(idx + CW'(1));
      end
      S_SHWR: begin
        we    = 1'b1;
        wdata = rdata;
      end
      S_WR: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= state == S_DONE;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur       <= item;
            idx       <= '0;
            have_prev <= 1'b0;
            result    <= '0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cur.command == fea_pkg::CMD_RELEASE) begin
            if (stop_rel) begin
              pos       <= idx;
              nxt       <= rdata;
              nxt_valid <= in_list;
              state     <= S_DEC;
            end else begin
              prev      <= rdata;
              have_prev <= 1'b1;
              idx       <= idx + CW'(1);
            end
          end else begin
            if (fit) begin
              pos   <= idx;
              hold  <= rdata;
              state <= S_DEC;
            end else if (!in_list) begin
              state <= S_DONE;
            end else begin
              idx <= idx + CW'(1);
            end
          end
        end
        S_DEC: begin
          if (cur.command == fea_pkg::CMD_ALLOCATE) begin
            result.found       <= 1'b1;
            result.alloc_start <= hold.start;
            if (hold.length == cur.extent_length) begin
              grow  <= 1'b0;
              count <= count - CW'(1);
              state <= (pos + CW'(1) < count) ? S_SHRD : S_DONE;
            end else begin
              hold.start  <= hold.start + cur.extent_length;
              hold.length <= hold.length - cur.extent_length;
              state       <= S_WR;
            end
          end else if (nxt_valid && sum_end == nxt.start) begin
            hold.start  <= cur.extent_start;
            hold.length <= nxt.length + cur.extent_length;
            state       <= S_WR;
          end else if (have_prev && prev_end == cur.extent_start) begin
            hold.start  <= prev.start;
            hold.length <= prev.length + cur.extent_length;
            idx         <= idx - CW'(1);
            state       <= S_WR;
          end else if (count >= CW'(MAX_EXTENTS)) begin
            result.overflow <= 1'b1;
            state           <= S_DONE;
          end else begin
            grow        <= 1'b1;
            count       <= count + CW'(1);
            idx         <= count;
            hold.start  <= cur.extent_start;
            hold.length <= cur.extent_length;
            state       <= (count == pos) ? S_WR : S_SHRD;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          if (grow) begin
            idx   <= idx - CW'(1);
            state <= (idx - CW'(1) == pos) ? S_WR : S_SHRD;
          end else begin
            idx   <= idx + CW'(1);
            state <= (idx + CW'(1) < count) ? S_SHRD : S_DONE;
          end
        end
        S_WR: begin
          state <= S_DONE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_EXTENTS)) else $error("entry count beyond capacity");

  a_no_both: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.overflow)) else $error("found and overflow together");

  a_idle_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item not taken");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

endmodule
